// ----- rtl/core/efd_pkg.sv -----
// ----------------------------------------------------------------------------
// efd_pkg
// shared constants and helpers for the escaped frame decoder with crc-8
// ----------------------------------------------------------------------------
package efd_pkg;

  localparam int unsigned DEF_MAX_ADDRESS_BYTES = 4;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 1'b1;

  localparam logic [7:0] MAGIC_RESET  = 8'd254;
  localparam logic [7:0] ESCAPE_RESET = 8'd253;
  localparam logic [7:0] ESCAPE_XOR   = 8'h20;
  localparam logic [7:0] CRC_POLY     = 8'h8C;

  localparam logic [2:0] KIND_LENGTH = 3'd0;
  localparam logic [2:0] KIND_ADDR   = 3'd1;
  localparam logic [2:0] KIND_NUM    = 3'd2;
  localparam logic [2:0] KIND_TYPE   = 3'd3;
  localparam logic [2:0] KIND_DATA   = 3'd4;
  localparam logic [2:0] KIND_STATUS = 3'd5;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_CRC      = 2'd1;
  localparam logic [1:0] ERR_NO_END   = 2'd2;
  localparam logic [1:0] ERR_TOO_SHORT = 2'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic [1:0] addr_index;
    logic [7:0] payload_index;
    logic [1:0] error_code;
    logic       last;
  } efd_result_t;

  // reflected crc-8, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/efd_if.sv -----
// ----------------------------------------------------------------------------
// efd_if
// valid/ready channels for raw link bytes and decoded results
// ----------------------------------------------------------------------------
interface efd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] kind;
  logic [1:0] addr_index;
  logic [7:0] payload_index;
  logic [1:0] error_code;
  logic       last;

  modport source (output valid, output out_byte, output kind, output addr_index,
                  output payload_index, output error_code, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input addr_index,
                  input payload_index, input error_code, input last, output ready);
endinterface

// ----- rtl/core/escaped_frame_decoder_crc8.sv -----
// ----------------------------------------------------------------------------
// escaped_frame_decoder_crc8
// byte-stuffed frame decoder: unescapes link bytes, tags frame fields,
// checks crc-8 and end magic, closes each frame with a status result
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_if    in   valid/ready    rx_byte
//  out_if   out  valid/ready    out_byte kind addr_index payload_index error_code last
//  cfg      in   cfg_we         cfg_idx cfg_wdata
//
//  one byte per cycle while in_if.ready is high; each transaction is decoded in the cycle it is taken,
//  and its result, if any, sits in the output register the next cycle
//  in_if.ready drops only while a result is held and out_if.ready is low
//  rst_n is synchronous, active low: hunting, crc cleared, registers but the result register at defaults
// ----------------------------------------------------------------------------
module escaped_frame_decoder_crc8 #(
  parameter int unsigned MAX_ADDRESS_BYTES = efd_pkg::DEF_MAX_ADDRESS_BYTES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  efd_in_if.sink                         in_if,
  efd_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [efd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [efd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import efd_pkg::*;

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_ADDR = 3'd2;
  localparam logic [2:0] PH_NUM  = 3'd3;
  localparam logic [2:0] PH_TYPE = 3'd4;
  localparam logic [2:0] PH_DATA = 3'd5;
  localparam logic [2:0] PH_CRC  = 3'd6;
  localparam logic [2:0] PH_END  = 3'd7;

  localparam logic [2:0] ADDR_MAX = 3'(MAX_ADDRESS_BYTES);

  logic [7:0]  magic_r, escape_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        esc_r, esc_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [2:0]  acnt_r, acnt_nxt;
  logic [7:0]  drem_r, drem_nxt;
  logic [7:0]  dpos_r, dpos_nxt;

  logic        out_valid_r;
  efd_result_t res_r, res_nxt;
  logic        emit;

  logic        in_fire;
  logic [7:0]  b;
  logic [8:0]  need;
  logic        too_short;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  assign b         = esc_r ? (in_if.rx_byte ^ ESCAPE_XOR) : in_if.rx_byte;
  assign need      = 9'(acnt_r) + 9'd2;
  assign too_short = 9'(len_r) < need;

  always_comb begin
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    esc_nxt   = esc_r;
    len_nxt   = len_r;
    acnt_nxt  = acnt_r;
    drem_nxt  = drem_r;
    dpos_nxt  = dpos_r;
    emit      = 1'b0;
    res_nxt   = '0;
    if (phase_r == PH_HUNT) begin
      if (in_if.rx_byte == magic_r) begin
        phase_nxt = PH_LEN;
        crc_nxt   = '0;
        esc_nxt   = 1'b0;
        len_nxt   = '0;
        acnt_nxt  = '0;
        drem_nxt  = '0;
        dpos_nxt  = '0;
      end
    end else if (phase_r == PH_END) begin
      emit             = 1'b1;
      res_nxt.kind     = KIND_STATUS;
      res_nxt.last     = 1'b1;
      if (too_short) begin
        res_nxt.error_code = ERR_TOO_SHORT;
      end else if (in_if.rx_byte != magic_r) begin
        res_nxt.error_code = ERR_NO_END;
      end else if (crc_r != 8'd0) begin
        res_nxt.error_code = ERR_CRC;
      end else begin
        res_nxt.error_code = ERR_OK;
      end
      phase_nxt = PH_HUNT;
      esc_nxt   = 1'b0;
    end else if (!esc_r && in_if.rx_byte == escape_r) begin
      esc_nxt = 1'b1;
    end else begin
      esc_nxt          = 1'b0;
      crc_nxt          = crc8_byte(crc_r, b);
      res_nxt.out_byte = b;
      case (phase_r)
        PH_LEN: begin
          len_nxt      = b;
          phase_nxt    = PH_ADDR;
          emit         = 1'b1;
          res_nxt.kind = KIND_LENGTH;
        end
        PH_ADDR: begin
          acnt_nxt           = acnt_r + 3'd1;
          if (b == 8'd0 || acnt_nxt >= ADDR_MAX) begin
            phase_nxt = PH_NUM;
          end
          emit               = 1'b1;
          res_nxt.kind       = KIND_ADDR;
          res_nxt.addr_index = acnt_r[1:0];
        end
        PH_NUM: begin
          phase_nxt    = PH_TYPE;
          emit         = 1'b1;
          res_nxt.kind = KIND_NUM;
        end
        PH_TYPE: begin
          drem_nxt     = too_short ? 8'd0 : 8'(9'(len_r) - need);
          dpos_nxt     = '0;
          phase_nxt    = (drem_nxt != 8'd0) ? PH_DATA : PH_CRC;
          emit         = 1'b1;
          res_nxt.kind = KIND_TYPE;
        end
        PH_DATA: begin
          dpos_nxt              = dpos_r + 8'd1;
          drem_nxt              = drem_r - 8'd1;
          if (drem_nxt == 8'd0) begin
            phase_nxt = PH_CRC;
          end
          emit                  = 1'b1;
          res_nxt.kind          = KIND_DATA;
          res_nxt.payload_index = dpos_r;
        end
        default: begin
          phase_nxt = PH_END;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r     <= MAGIC_RESET;
      escape_r    <= ESCAPE_RESET;
      phase_r     <= PH_HUNT;
      crc_r       <= '0;
      esc_r       <= 1'b0;
      len_r       <= '0;
      acnt_r      <= '0;
      drem_r      <= '0;
      dpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MAGIC:  magic_r  <= cfg_wdata;
          CFG_ESCAPE: escape_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        phase_r <= phase_nxt;
        crc_r   <= crc_nxt;
        esc_r   <= esc_nxt;
        len_r   <= len_nxt;
        acnt_r  <= acnt_nxt;
        drem_r  <= drem_nxt;
        dpos_r  <= dpos_nxt;
      end
      if (in_fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.out_byte      = res_r.out_byte;
  assign out_if.kind          = res_r.kind;
  assign out_if.addr_index    = res_r.addr_index;
  assign out_if.payload_index = res_r.payload_index;
  assign out_if.error_code    = res_r.error_code;
  assign out_if.last          = res_r.last;

`ifndef NO_ASSERTIONS
  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.kind == KIND_STATUS |-> res_r.last && res_r.out_byte == 8'd0)
    else $error("status result malformed");

  a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == PH_END |=> phase_r == PH_HUNT && out_valid_r)
    else $error("end byte did not close the frame");

  a_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acnt_r <= ADDR_MAX)
    else $error("address count past limit");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> drem_r != 8'd0)
    else $error("data phase with nothing remaining");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |-> !in_if.ready)
    else $error("input taken while result stalled");
`endif

endmodule
